/* hdl/bitwise_huffman_table_decoder_macros.svh */
// assertion helpers shared by the decoder rtl
`ifndef BITWISE_HUFFMAN_TABLE_DECODER_MACROS_SVH
`define BITWISE_HUFFMAN_TABLE_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BHTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BHTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bhtd_pkg.sv */
package bhtd_pkg;

    localparam int BHTD_NODE_COUNT = 128;
    localparam int SYM_COUNT       = 128;

    // input item kinds
    localparam logic [2:0] KIND_LEFT  = 3'd0;
    localparam logic [2:0] KIND_RIGHT = 3'd1;
    localparam logic [2:0] KIND_SYM   = 3'd2;
    localparam logic [2:0] KIND_START = 3'd3;
    localparam logic [2:0] KIND_BYTE  = 3'd4;

    // result kinds
    localparam logic RK_SYMBOL = 1'b0;
    localparam logic RK_ADDR   = 1'b1;

    // register indexes
    localparam logic [1:0] REG_TEXT_BASE = 2'd0;
    localparam logic [1:0] REG_END_CODE  = 2'd1;
    localparam logic [1:0] REG_SPB       = 2'd2;

    localparam logic [3:0] SPB_RESET = 4'd4;

    // table write request
    typedef struct packed {
        logic       wr_left;
        logic       wr_right;
        logic       wr_sym;
        logic [6:0] idx;
        logic [7:0] val;
    } tbl_wr_t;

    // table read request
    typedef struct packed {
        logic       child_en;
        logic [6:0] node;
        logic       sym_en;
        logic [6:0] sym_idx;
    } tbl_rd_t;

endpackage

/* hdl/bhtd_tables.sv */
module bhtd_tables import bhtd_pkg::*; #(
    parameter int NODE_COUNT = BHTD_NODE_COUNT
) (
    input  logic       aclk,
    input  tbl_wr_t    wr,
    input  tbl_rd_t    rd,
    output logic [7:0] left_q,
    output logic [7:0] right_q,
    output logic [7:0] sym_q
);

    localparam int         NODE_AW  = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
    localparam logic [7:0] NODE_LIM = 8'(NODE_COUNT);

    logic [7:0] left_mem  [NODE_COUNT];
    logic [7:0] right_mem [NODE_COUNT];
    logic [7:0] sym_mem   [SYM_COUNT];

    logic [7:0] left_rd_reg;
    logic [7:0] right_rd_reg;
    logic [7:0] sym_rd_reg;
    logic       node_ok_reg;

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = ({1'b0, wr.idx} < NODE_LIM);
    assign rd_in_range = ({1'b0, rd.node} < NODE_LIM);

    // child tables, writes beyond the node count are dropped
    always_ff @(posedge aclk) begin
        if (wr.wr_left && wr_in_range) begin
            left_mem[wr.idx[NODE_AW-1:0]] <= wr.val;
        end
        if (wr.wr_right && wr_in_range) begin
            right_mem[wr.idx[NODE_AW-1:0]] <= wr.val;
        end
        if (rd.child_en) begin
            left_rd_reg  <= left_mem[rd.node[NODE_AW-1:0]];
            right_rd_reg <= right_mem[rd.node[NODE_AW-1:0]];
            node_ok_reg  <= rd_in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.wr_sym) begin
            sym_mem[wr.idx] <= wr.val;
        end
        if (rd.sym_en) begin
            sym_rd_reg <= sym_mem[rd.sym_idx];
        end
    end

    // out-of-range node reads as zero, back to the root
    assign left_q  = node_ok_reg ? left_rd_reg  : 8'h00;
    assign right_q = node_ok_reg ? right_rd_reg : 8'h00;
    assign sym_q   = sym_rd_reg;

endmodule

/* hdl/bitwise_huffman_table_decoder.sv */
// a table write goes in on acceptance and an ignored item is dropped; a start item registers
// its address beat once the output register is free, then returns to idle for the next item
// one item at a time: for a byte each bit reads the child tables and steps the tree, a leaf
// also reads the symbol map, and a flush ends the byte; a waiting beat holds the walk
// reset: aresetn low at a rising edge clears the walk, the block state and the registers
// (screens_per_block to 4); the tables keep their contents and are undefined until written
`include "bitwise_huffman_table_decoder_macros.svh"

module bitwise_huffman_table_decoder import bhtd_pkg::*; #(
    parameter int NODE_COUNT = BHTD_NODE_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // table_index[6:0], table_value[14:7],
                                   // packed_pointer[30:15], data_byte[38:31], zero pad
    input  logic [2:0]  s_tuser,   // kind[2:0]

    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // symbol[7:0], byte_address[31:8], block_done[32],
                                   // zero pad
    output logic        m_tuser,   // result_kind[0]
    output logic        m_tlast,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for an item
    localparam logic [2:0] ST_ADDR  = 3'd1;  // emitting the block start address
    localparam logic [2:0] ST_READ  = 3'd2;  // child table read issued
    localparam logic [2:0] ST_STEP  = 3'd3;  // one tree step on the current bit
    localparam logic [2:0] ST_SYM   = 3'd4;  // leaf hit, symbol map read back
    localparam logic [2:0] ST_FLUSH = 3'd5;  // last held symbol goes out with tlast

    // input field views
    logic [2:0]  in_kind;
    logic [6:0]  in_index;
    logic [7:0]  in_value;
    logic [15:0] in_ptr;
    logic [7:0]  in_byte;

    assign in_kind  = s_tuser;
    assign in_index = s_tdata[6:0];
    assign in_value = s_tdata[14:7];
    assign in_ptr   = s_tdata[30:15];
    assign in_byte  = s_tdata[38:31];

    // configuration registers
    logic [23:0] text_base_reg;
    logic [7:0]  end_code_reg;
    logic [3:0]  spb_reg;

    // control state
    logic [2:0]  state_reg,      state_next;
    logic [6:0]  node_reg,       node_next;
    logic [2:0]  start_bits_reg, start_bits_next;
    logic        first_pend_reg, first_pend_next;
    logic [3:0]  screen_reg,     screen_next;
    logic        active_reg,     active_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        out_valid_reg,  out_valid_next;

    // payload
    logic [7:0]  shift_reg,      shift_next;
    logic [3:0]  cnt_reg,        cnt_next;
    logic [23:0] addr_reg,       addr_next;
    logic [7:0]  pend_sym_reg,   pend_sym_next;
    logic        pend_done_reg,  pend_done_next;
    logic        out_kind_reg,   out_kind_next;
    logic [7:0]  out_sym_reg,    out_sym_next;
    logic [23:0] out_addr_reg,   out_addr_next;
    logic        out_done_reg,   out_done_next;
    logic        out_last_reg,   out_last_next;

    logic        accept;
    logic        out_free;
    logic        cfg_wr;
    logic [7:0]  child;
    logic [3:0]  screen_inc;
    logic        end_hit;
    logic        blk_done;

    tbl_wr_t     tbl_wr;
    tbl_rd_t     tbl_rd;
    logic [7:0]  left_q;
    logic [7:0]  right_q;
    logic [7:0]  sym_q;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // output register is free this cycle, or drains this cycle
    assign out_free = !out_valid_reg || m_tready;

    // table writes go straight in on acceptance
    always_comb begin
        tbl_wr.wr_left  = accept && (in_kind == KIND_LEFT);
        tbl_wr.wr_right = accept && (in_kind == KIND_RIGHT);
        tbl_wr.wr_sym   = accept && (in_kind == KIND_SYM);
        tbl_wr.idx      = in_index;
        tbl_wr.val      = in_value;
    end

    bhtd_tables #(
        .NODE_COUNT (NODE_COUNT)
    ) u_tables (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .left_q  (left_q),
        .right_q (right_q),
        .sym_q   (sym_q)
    );

    // tree step and leaf bookkeeping
    assign child      = shift_reg[7] ? right_q : left_q;
    assign screen_inc = screen_reg + 4'd1;
    assign end_hit    = (sym_q == end_code_reg);
    assign blk_done   = end_hit && (screen_inc >= spb_reg);

    always_comb begin
        state_next      = state_reg;
        node_next       = node_reg;
        start_bits_next = start_bits_reg;
        first_pend_next = first_pend_reg;
        screen_next     = screen_reg;
        active_next     = active_reg;
        pend_valid_next = pend_valid_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_sym_next    = out_sym_reg;
        out_addr_next   = out_addr_reg;
        out_done_next   = out_done_reg;
        out_last_next   = out_last_reg;

        tbl_rd.child_en = 1'b0;
        tbl_rd.node     = node_reg;
        tbl_rd.sym_en   = 1'b0;
        tbl_rd.sym_idx  = child[6:0];

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        KIND_START: begin
                            // offset: low byte plus the top five bits moved down
                            start_bits_next = in_ptr[10:8];
                            first_pend_next = 1'b1;
                            active_next     = 1'b1;
                            screen_next     = 4'd0;
                            node_next       = 7'd0;
                            addr_next       = text_base_reg
                                            + {11'd0, in_ptr[15:11], in_ptr[7:0]};
                            state_next      = ST_ADDR;
                        end
                        KIND_BYTE: begin
                            if (active_reg) begin
                                if (first_pend_reg) begin
                                    // only the low start_bits+1 bits of the first byte
                                    shift_next = in_byte << (3'd7 - start_bits_reg);
                                    cnt_next   = {1'b0, start_bits_reg} + 4'd1;
                                end else begin
                                    shift_next = in_byte;
                                    cnt_next   = 4'd8;
                                end
                                first_pend_next = 1'b0;
                                state_next      = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADDR: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RK_ADDR;
                    out_sym_next   = 8'd0;
                    out_addr_next  = addr_reg;
                    out_done_next  = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_READ: begin
                tbl_rd.child_en = 1'b1;
                state_next      = ST_STEP;
            end
            ST_STEP: begin
                shift_next = {shift_reg[6:0], 1'b0};
                cnt_next   = cnt_reg - 4'd1;
                if (child[7]) begin
                    tbl_rd.sym_en = 1'b1;
                    state_next    = ST_SYM;
                end else begin
                    node_next  = child[6:0];
                    state_next = (cnt_reg == 4'd1) ? ST_FLUSH : ST_READ;
                end
            end
            ST_SYM: begin
                // the held symbol is known not to be last once another leaf shows up
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = RK_SYMBOL;
                        out_sym_next   = pend_sym_reg;
                        out_addr_next  = 24'd0;
                        out_done_next  = pend_done_reg;
                        out_last_next  = 1'b0;
                    end
                    node_next       = 7'd0;
                    pend_valid_next = 1'b1;
                    pend_sym_next   = sym_q;
                    pend_done_next  = blk_done;
                    if (end_hit) begin
                        screen_next = screen_inc;
                    end
                    if (blk_done) begin
                        active_next = 1'b0;
                        state_next  = ST_FLUSH;
                    end else begin
                        state_next = (cnt_reg == 4'd0) ? ST_FLUSH : ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RK_SYMBOL;
                    out_sym_next    = pend_sym_reg;
                    out_addr_next   = 24'd0;
                    out_done_next   = pend_done_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_reg       <= 7'd0;
            start_bits_reg <= 3'd0;
            first_pend_reg <= 1'b0;
            screen_reg     <= 4'd0;
            active_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_reg       <= node_next;
            start_bits_reg <= start_bits_next;
            first_pend_reg <= first_pend_next;
            screen_reg     <= screen_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg     <= shift_next;
        cnt_reg       <= cnt_next;
        addr_reg      <= addr_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        out_kind_reg  <= out_kind_next;
        out_sym_reg   <= out_sym_next;
        out_addr_reg  <= out_addr_next;
        out_done_reg  <= out_done_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_done_reg, out_addr_reg, out_sym_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // register port, index from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_base_reg <= 24'd0;
            end_code_reg  <= 8'd0;
            spb_reg       <= SPB_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TEXT_BASE: text_base_reg <= pwdata[23:0];
                REG_END_CODE:  end_code_reg  <= pwdata[7:0];
                REG_SPB:       spb_reg       <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TEXT_BASE: prdata = {8'd0, text_base_reg};
            REG_END_CODE:  prdata = {24'd0, end_code_reg};
            REG_SPB:       prdata = {28'd0, spb_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // checks on the sequencer
    `BHTD_ASSERT_IMP(a_idle_no_held_sym, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg, "symbol still held while taking new items")
    `BHTD_ASSERT_IMP(a_done_ends_block, aclk, aresetn, pend_valid_reg && pend_done_reg, !active_reg, "block still active after its last screen")
    `BHTD_ASSERT_IMP(a_done_is_last, aclk, aresetn, out_valid_reg && out_done_reg, out_last_reg, "block end beat not marked last")
    `BHTD_ASSERT_IMP(a_read_has_bits, aclk, aresetn, state_reg == ST_READ, cnt_reg != 4'd0, "tree step issued with no bits left")
    `BHTD_ASSERT_NXT(a_start_arms, aclk, aresetn, accept && in_kind == KIND_START, active_reg && state_reg == ST_ADDR, "start item did not arm the block")

endmodule
